/* hdl/mntp_pkg.sv */
// Shared types, codes and note lookup tables for the note to register-write block.
package mntp_pkg;

  localparam logic [1:0] OP_ON  = 2'd0;
  localparam logic [1:0] OP_OFF = 2'd1;

  localparam logic [1:0] VOICE_PULSE0 = 2'd0;
  localparam logic [1:0] VOICE_PULSE1 = 2'd1;
  localparam logic [1:0] VOICE_WAVE   = 2'd2;
  localparam logic [1:0] VOICE_NOISE  = 2'd3;

  localparam int IN_W   = 32;
  localparam int OUT_W  = 16;
  localparam int FIFO_DEPTH = 2;

  localparam logic [127:0] SCALE_E18 = 128'd1000000000000000000;

  typedef logic [63:0] root_t [12];
  localparam root_t SEMITONE_ROOT = '{
    64'd1000000000000000000, 64'd1059463094359295265, 64'd1122462048309372981,
    64'd1189207115002721067, 64'd1259921049894873165, 64'd1334839854170034365,
    64'd1414213562373095049, 64'd1498307076876681499, 64'd1587401051968199475,
    64'd1681792830507429086, 64'd1781797436280678610, 64'd1887748625363386993};

  // Noise divisor per ratio code: 105 / odd part, and its power-of-two part.
  typedef int ratio_t [8];
  localparam ratio_t NOISE_MUL = '{105, 105, 105, 35, 105, 21, 35, 15};
  localparam ratio_t NOISE_SH  = '{3, 4, 5, 4, 6, 4, 5, 4};

  typedef logic [10:0] period_rom_t [256];
  typedef logic [7:0]  noise_rom_t  [256];
  typedef logic [3:0]  vol_rom_t    [256];

  typedef struct packed {
    logic [1:0]  voice;
    logic        silence;
    logic [3:0]  vol;
    logic [10:0] code;
  } cmd_t;

  typedef struct packed {
    logic [5:0] offset;
    logic [7:0] data;
    logic       last;
  } wr_t;

  function automatic logic [10:0] period_code(int note, logic [127:0] numer);
    int e;
    int qq;
    int k;
    logic [127:0] num;
    logic [127:0] den;
    logic [127:0] n2;
    logic [127:0] d2;
    logic [127:0] rem;
    logic [127:0] quo;
    e = note + 3;
    qq = e / 12 - 6;
    k = e % 12;
    num = numer * SCALE_E18;
    den = 128'd55 * {64'd0, SEMITONE_ROOT[k]};
    if (qq < 0) begin
      num = num << (-qq);
    end else begin
      den = den << qq;
    end
    n2 = (num << 1) + den;
    d2 = den << 1;
    rem = '0;
    quo = '0;
    for (int i = 127; i >= 0; i--) begin
      rem = {rem[126:0], n2[i]};
      if (rem >= d2) begin
        rem = rem - d2;
        quo[i] = 1'b1;
      end
    end
    if (quo >= 128'd2048) return 11'd0;
    if (quo == 128'd0) return 11'd2047;
    return 11'(128'd2048 - quo);
  endfunction

  function automatic logic [7:0] noise_code(int note);
    int e;
    logic [127:0] ft;
    logic [127:0] nf;
    logic [127:0] diff;
    logic [127:0] best_diff;
    logic [7:0]   best;
    logic         have;
    e = note + 3;
    ft = (128'd46200 * {64'd0, SEMITONE_ROOT[e % 12]}) << (e / 12);
    best_diff = '0;
    best = '0;
    have = 1'b0;
    for (int s = 0; s < 14; s++) begin
      for (int r = 0; r < 8; r++) begin
        nf = (SCALE_E18 * 128'(NOISE_MUL[r])) << (28 - s - NOISE_SH[r]);
        diff = (ft < nf) ? nf - ft : ft - nf;
        if (!have || diff < best_diff) begin
          have = 1'b1;
          best_diff = diff;
          best = 8'((s << 4) | r);
        end
      end
    end
    return best;
  endfunction

  function automatic period_rom_t build_period_rom(logic [127:0] numer);
    period_rom_t rom;
    for (int n = 0; n < 256; n++) begin
      rom[n] = period_code(n, numer);
    end
    return rom;
  endfunction

  function automatic noise_rom_t build_noise_rom();
    noise_rom_t rom;
    for (int n = 0; n < 256; n++) begin
      rom[n] = noise_code(n);
    end
    return rom;
  endfunction

  function automatic vol_rom_t build_vol_rom();
    vol_rom_t rom;
    int t;
    for (int v = 0; v < 256; v++) begin
      t = v * 15 / 127;
      if (t < 1) t = 1;
      if (t > 15) t = 15;
      rom[v] = 4'(t);
    end
    return rom;
  endfunction

  localparam period_rom_t PULSE_ROM = build_period_rom(128'd16384);
  localparam period_rom_t WAVE_ROM  = build_period_rom(128'd8192);
  localparam noise_rom_t  NOISE_ROM = build_noise_rom();
  localparam vol_rom_t    VOL_ROM   = build_vol_rom();

endpackage

/* hdl/mntp_front.sv */
// Command intake: decode, look up period/noise code and volume, queue the command.
module mntp_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [mntp_pkg::IN_W-1:0] s_tdata,
  input  logic                      q_full,
  output logic                      q_push,
  output mntp_pkg::cmd_t            q_cmd
);
  import mntp_pkg::*;

  logic [1:0] op;
  logic [1:0] voice;
  logic [7:0] note;
  logic [7:0] velocity;
  logic       has_note_args;
  logic       accept;

  assign op            = s_tdata[1:0];
  assign voice         = s_tdata[3:2];
  assign note          = s_tdata[17:10];
  assign velocity      = s_tdata[25:18];
  assign has_note_args = s_tdata[26];

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;
  assign q_push   = accept && (op == OP_OFF || (op == OP_ON && has_note_args));

  always_comb begin
    q_cmd.voice   = voice;
    q_cmd.silence = (op == OP_OFF) || (velocity == 8'd0);
    q_cmd.vol     = VOL_ROM[velocity];
    case (voice)
      VOICE_NOISE: q_cmd.code = {3'd0, NOISE_ROM[note]};
      VOICE_WAVE:  q_cmd.code = WAVE_ROM[note];
      default:     q_cmd.code = PULSE_ROM[note];
    endcase
  end

  logic unused_ok;
  assign unused_ok = &{1'b0, clk, rst, s_tdata[9:4], s_tdata[31:27]};

endmodule

/* hdl/mntp_fifo.sv */
// Two-entry command queue between intake and write sequencer.
module mntp_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  mntp_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output mntp_pkg::cmd_t head_cmd
);
  import mntp_pkg::*;

  cmd_t       mem [FIFO_DEPTH];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full       = (count == 2'(FIFO_DEPTH));
  assign head_valid = (count != 2'd0);
  assign head_cmd   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_cmd;
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

/* hdl/mntp_back.sv */
// Write sequencer: expand the queued command into register writes.
module mntp_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       head_valid,
  input  mntp_pkg::cmd_t             head_cmd,
  output logic                       pop,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [mntp_pkg::OUT_W-1:0] m_tdata,
  output logic                       m_tlast
);
  import mntp_pkg::*;

  logic [2:0] idx;
  logic       advance;
  wr_t        wr;
  logic [7:0] lo;
  logic [7:0] hi;
  logic [7:0] volb;
  logic [5:0] base;

  assign lo   = head_cmd.code[7:0];
  assign hi   = {5'b10000, head_cmd.code[10:8]};
  assign volb = {head_cmd.vol, 4'd0};
  assign base = (head_cmd.voice == VOICE_PULSE0) ? 6'h01 : 6'h06;

  always_comb begin
    wr = '{offset: 6'h00, data: 8'h00, last: 1'b1};
    if (head_cmd.silence) begin
      case (head_cmd.voice)
        VOICE_PULSE0: wr = (idx == 3'd0) ? wr_t'{6'h02, 8'h00, 1'b0} : wr_t'{6'h04, 8'h80, 1'b1};
        VOICE_PULSE1: wr = (idx == 3'd0) ? wr_t'{6'h07, 8'h00, 1'b0} : wr_t'{6'h09, 8'h80, 1'b1};
        VOICE_WAVE:   wr = '{6'h0A, 8'h00, 1'b1};
        default:      wr = (idx == 3'd0) ? wr_t'{6'h11, 8'h00, 1'b0} : wr_t'{6'h13, 8'h80, 1'b1};
      endcase
    end else begin
      case (head_cmd.voice)
        VOICE_WAVE: begin
          case (idx)
            3'd0:    wr = '{6'h0A, 8'h80, 1'b0};
            3'd1:    wr = '{6'h0B, 8'hFF, 1'b0};
            3'd2:    wr = '{6'h0C, 8'h20, 1'b0};
            3'd3:    wr = '{6'h0D, lo, 1'b0};
            default: wr = '{6'h0E, hi, 1'b1};
          endcase
        end
        VOICE_NOISE: begin
          case (idx)
            3'd0:    wr = '{6'h10, 8'h00, 1'b0};
            3'd1:    wr = '{6'h11, volb, 1'b0};
            3'd2:    wr = '{6'h12, lo, 1'b0};
            default: wr = '{6'h13, 8'h80, 1'b1};
          endcase
        end
        default: begin
          case (idx)
            3'd0:    wr = '{base, 8'h80, 1'b0};
            3'd1:    wr = '{base + 6'd1, volb, 1'b0};
            3'd2:    wr = '{base + 6'd2, lo, 1'b0};
            default: wr = '{base + 6'd3, hi, 1'b1};
          endcase
        end
      endcase
    end
  end

  assign advance = head_valid && (!m_tvalid || m_tready);
  assign pop     = advance && wr.last;

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {2'd0, wr.data, wr.offset};
      m_tlast <= wr.last;
    end
    if (rst) begin
      m_tvalid <= 1'b0;
      idx      <= 3'd0;
    end else begin
      if (advance) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      if (pop) idx <= 3'd0;
      else if (advance) idx <= idx + 3'd1;
    end
  end

  a_idx_range: assert property (@(posedge clk) disable iff (rst) idx <= 3'd4)
    else $error("write index out of range");
  a_pop_valid: assert property (@(posedge clk) disable iff (rst) pop |-> head_valid)
    else $error("pop from empty queue");
  a_idx_clear: assert property (@(posedge clk) disable iff (rst) pop |=> idx == 3'd0)
    else $error("index not cleared after run");
  a_last_out: assert property (@(posedge clk) disable iff (rst) pop |=> m_tvalid && m_tlast)
    else $error("run end not marked");

endmodule

/* hdl/midi_note_to_psg_register_writes.sv */
// Top level: note commands in, sound-chip register writes out.
//  channel | dir | tdata (low bit up)                               | tuser/tlast
//  s_*     | in  | op[1:0] channel_byte[9:2] note[17:10]           | -
//          |     | velocity[25:18] has_note_args[26]                |
//  m_*     | out | reg_offset[5:0] reg_data[13:6]                   | tlast = last_write
// A command is taken when the queue has room; the single write sequencer emits one write per
// cycle while m_tready allows, up to 5 writes per command. Two commands queue between intake and sequencer.
// Reset clears the queue and the output valid. s_tready drops only when the queue is full.
module midi_note_to_psg_register_writes (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // op, channel_byte, note, velocity, has_note_args
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // reg_offset, reg_data
  output logic        m_tlast
);
  import mntp_pkg::*;

  logic q_full;
  logic q_push;
  cmd_t q_cmd;
  logic pop;
  logic head_valid;
  cmd_t head_cmd;

  mntp_front u_front (
    .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .q_full(q_full), .q_push(q_push), .q_cmd(q_cmd)
  );

  mntp_fifo u_fifo (
    .clk(clk), .rst(rst), .push(q_push), .push_cmd(q_cmd), .full(q_full),
    .pop(pop), .head_valid(head_valid), .head_cmd(head_cmd)
  );

  mntp_back u_back (
    .clk(clk), .rst(rst), .head_valid(head_valid), .head_cmd(head_cmd), .pop(pop),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

endmodule

/* dv/mntp_checker.sv */
`timescale 1ns / 100ps
// Checker: predicts register-write runs from accepted note commands and compares the outputs.
module mntp_checker
  import mntp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [31:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [15:0] m_tdata,
  input  logic        m_tlast,
  output int          fail_count,
  output int          writes_pending
);

  localparam logic [5:0] R_P0_DUTY  = 6'h01;
  localparam logic [5:0] R_P0_ENV   = 6'h02;
  localparam logic [5:0] R_P0_HI    = 6'h04;
  localparam logic [5:0] R_P1_DUTY  = 6'h06;
  localparam logic [5:0] R_P1_ENV   = 6'h07;
  localparam logic [5:0] R_P1_HI    = 6'h09;
  localparam logic [5:0] R_WAVE_EN  = 6'h0A;
  localparam logic [5:0] R_WAVE_LEN = 6'h0B;
  localparam logic [5:0] R_WAVE_VOL = 6'h0C;
  localparam logic [5:0] R_WAVE_LO  = 6'h0D;
  localparam logic [5:0] R_WAVE_HI  = 6'h0E;
  localparam logic [5:0] R_NZ_LEN   = 6'h10;
  localparam logic [5:0] R_NZ_ENV   = 6'h11;
  localparam logic [5:0] R_NZ_POLY  = 6'h12;
  localparam logic [5:0] R_NZ_CTRL  = 6'h13;

  typedef struct {
    logic [5:0] offset;
    logic [7:0] data;
    logic       last;
  } reg_write_t;

  logic [63:0] twelfth_root [12] = '{
    64'd1000000000000000000, 64'd1059463094359295265, 64'd1122462048309372981,
    64'd1189207115002721067, 64'd1259921049894873165, 64'd1334839854170034365,
    64'd1414213562373095049, 64'd1498307076876681499, 64'd1587401051968199475,
    64'd1681792830507429086, 64'd1781797436280678610, 64'd1887748625363386993};

  logic [10:0] pulse_period [256];
  logic [10:0] wave_period  [256];
  logic [7:0]  noise_sel    [256];
  reg_write_t  write_q [$];
  logic        voice_on   [4];
  logic [7:0]  voice_note [4];

  function automatic logic [10:0] calc_period(int note, logic [127:0] numer);
    int e;
    int oct;
    logic [127:0] num;
    logic [127:0] den;
    logic [127:0] m;
    e = note + 3;
    oct = e / 12 - 6;
    num = numer * 128'd1000000000000000000;
    den = 128'd55 * {64'd0, twelfth_root[e % 12]};
    if (oct < 0) num = num << (-oct);
    else den = den << oct;
    m = (2 * num + den) / (2 * den);
    if (m >= 2048) return 11'd0;
    if (m == 0) return 11'd2047;
    return 11'(2048 - m);
  endfunction

  function automatic logic [7:0] calc_noise(int note);
    int e;
    int odd;
    int sh;
    logic [127:0] target;
    logic [127:0] cand;
    logic [127:0] d;
    logic [127:0] best_d;
    logic [7:0] best;
    e = note + 3;
    target = (128'd46200 * {64'd0, twelfth_root[e % 12]}) << (e / 12);
    best = '0;
    best_d = '1;
    for (int s = 0; s < 14; s++) begin
      for (int r = 0; r < 8; r++) begin
        odd = (r == 0) ? 8 : 16 * r;
        sh = 0;
        while (odd % 2 == 0) begin
          odd = odd / 2;
          sh++;
        end
        cand = (128'd1000000000000000000 * (105 / odd)) << (28 - s - sh);
        d = (target < cand) ? cand - target : target - cand;
        if ((s == 0 && r == 0) || d < best_d) begin
          best_d = d;
          best = 8'(s * 16 + r);
        end
      end
    end
    return best;
  endfunction

  initial begin
    for (int n = 0; n < 256; n++) begin
      pulse_period[n] = calc_period(n, 128'd16384);
      wave_period[n]  = calc_period(n, 128'd8192);
      noise_sel[n]    = calc_noise(n);
    end
  end

  function automatic void push_write(logic [5:0] off, logic [7:0] data);
    reg_write_t w;
    w.offset = off;
    w.data = data;
    w.last = 1'b0;
    write_q.push_back(w);
  endfunction

  function automatic void push_silence(logic [1:0] v);
    case (v)
      VOICE_PULSE0: begin
        push_write(R_P0_ENV, 8'h00);
        push_write(R_P0_HI, 8'h80);
      end
      VOICE_PULSE1: begin
        push_write(R_P1_ENV, 8'h00);
        push_write(R_P1_HI, 8'h80);
      end
      VOICE_WAVE: push_write(R_WAVE_EN, 8'h00);
      default: begin
        push_write(R_NZ_ENV, 8'h00);
        push_write(R_NZ_CTRL, 8'h80);
      end
    endcase
    voice_on[v] = 1'b0;
  endfunction

  function automatic void predict_writes(logic [31:0] cmd);
    logic [1:0] op;
    logic [1:0] v;
    logic [7:0] note;
    logic [7:0] vel;
    logic       args;
    int vol;
    int before_n;
    logic [10:0] code;
    logic [5:0] base;
    op = cmd[1:0];
    v = cmd[3:2];
    note = cmd[17:10];
    vel = cmd[25:18];
    args = cmd[26];
    before_n = write_q.size();
    if (op == OP_OFF || (op == OP_ON && args && vel == 0)) begin
      push_silence(v);
    end else if (op == OP_ON && args) begin
      voice_note[v] = note;
      voice_on[v] = 1'b1;
      vol = int'(vel) * 15 / 127;
      if (vol < 1) vol = 1;
      if (vol > 15) vol = 15;
      if (v == VOICE_NOISE) begin
        push_write(R_NZ_LEN, 8'h00);
        push_write(R_NZ_ENV, 8'(vol << 4));
        push_write(R_NZ_POLY, noise_sel[note]);
        push_write(R_NZ_CTRL, 8'h80);
      end else if (v == VOICE_WAVE) begin
        code = wave_period[note];
        push_write(R_WAVE_EN, 8'h80);
        push_write(R_WAVE_LEN, 8'hFF);
        push_write(R_WAVE_VOL, 8'h20);
        push_write(R_WAVE_LO, code[7:0]);
        push_write(R_WAVE_HI, {5'b10000, code[10:8]});
      end else begin
        code = pulse_period[note];
        base = (v == VOICE_PULSE0) ? R_P0_DUTY : R_P1_DUTY;
        push_write(base, 8'h80);
        push_write(base + 6'd1, 8'(vol << 4));
        push_write(base + 6'd2, code[7:0]);
        push_write(base + 6'd3, {5'b10000, code[10:8]});
      end
    end
    if (write_q.size() > before_n) write_q[write_q.size() - 1].last = 1'b1;
  endfunction

  always @(posedge clk) begin
    reg_write_t w;
    if (rst) begin
      write_q.delete();
      for (int i = 0; i < 4; i++) begin
        voice_on[i] = 1'b0;
        voice_note[i] = 8'd0;
      end
      fail_count <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (write_q.size() == 0) begin
          $error("unexpected write: reg_offset %0h reg_data %0h", m_tdata[5:0], m_tdata[13:6]);
          fail_count <= fail_count + 1;
        end else begin
          w = write_q.pop_front();
          if (m_tdata[5:0] !== w.offset || m_tdata[13:6] !== w.data || m_tlast !== w.last)
            fail_count <= fail_count + 1;
          if (m_tdata[5:0] !== w.offset)
            $error("reg_offset expected %0h actual %0h", w.offset, m_tdata[5:0]);
          if (m_tdata[13:6] !== w.data)
            $error("reg_data expected %0h actual %0h", w.data, m_tdata[13:6]);
          if (m_tlast !== w.last)
            $error("last_write expected %0b actual %0b", w.last, m_tlast);
        end
      end
      if (s_tvalid && s_tready) predict_writes(s_tdata);
    end
    writes_pending <= write_q.size();
  end

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 100ps
// Testbench top: drives note commands with random gaps and stalls, and gives the verdict.
module tb_top;
  import mntp_pkg::*;

  localparam logic [1:0] OP_OTHER = 2'd2;
  localparam logic [1:0] OP_SPARE = 2'd3;
  localparam int CYCLE_LIMIT = 600000;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;
  logic        m_tlast;
  int          fail_count;
  int          writes_pending;
  int          cycles;

  midi_note_to_psg_register_writes uut (.*);
  mntp_checker chk (.*);

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic int rand_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  always @(posedge clk) begin
    if (rst || (cycles / 2000) % 4 == 0) m_tready <= 1'b1;
    else m_tready <= (rand_gap() == 0);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("midi_note_to_psg_register_writes test failed");
      $finish;
    end
  end

  task automatic send_cmd(logic [1:0] op, logic [7:0] ch, logic [7:0] note,
                          logic [7:0] vel, logic args);
    int gap;
    gap = (cycles / 1500) % 3 == 0 ? 0 : rand_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {5'd0, args, vel, note, ch, op};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (writes_pending != 0) @(posedge clk);
  endtask

  initial begin
    logic [1:0] op;
    int p;
    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // extremes of note and velocity on every voice, then note-offs, commands without note args and other opcodes
    send_cmd(OP_ON, 8'd0, 8'd0, 8'd1, 1'b1);
    send_cmd(OP_ON, 8'd1, 8'd255, 8'd255, 1'b1);
    send_cmd(OP_ON, 8'd2, 8'd69, 8'd127, 1'b1);
    send_cmd(OP_ON, 8'd3, 8'd0, 8'd128, 1'b1);
    send_cmd(OP_ON, 8'd255, 8'd255, 8'd8, 1'b1);
    send_cmd(OP_ON, 8'd254, 8'd255, 8'd200, 1'b1);
    send_cmd(OP_ON, 8'd252, 8'd69, 8'd9, 1'b1);
    send_cmd(OP_ON, 8'd253, 8'd127, 8'd64, 1'b1);
    send_cmd(OP_ON, 8'd0, 8'd60, 8'd0, 1'b1);
    send_cmd(OP_ON, 8'd6, 8'd60, 8'd0, 1'b1);
    send_cmd(OP_OFF, 8'd1, 8'd255, 8'd255, 1'b0);
    send_cmd(OP_OFF, 8'd3, 8'd0, 8'd0, 1'b1);
    send_cmd(OP_OFF, 8'd2, 8'd0, 8'd0, 1'b0);
    send_cmd(OP_OFF, 8'd0, 8'd0, 8'd0, 1'b1);
    send_cmd(OP_ON, 8'd1, 8'd69, 8'd100, 1'b0);
    send_cmd(OP_OTHER, 8'd2, 8'd69, 8'd100, 1'b1);
    send_cmd(OP_SPARE, 8'd3, 8'd69, 8'd100, 1'b1);
    send_cmd(OP_ON, 8'd7, 8'd1, 8'd255, 1'b1);
    drain();

    for (int i = 0; i < 380; i++) begin
      p = $urandom_range(0, 99);
      if (p < 60) op = OP_ON;
      else if (p < 85) op = OP_OFF;
      else op = 2'($urandom_range(0, 3));
      send_cmd(op, 8'($urandom), 8'($urandom),
               ($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom),
               ($urandom_range(0, 9) != 0));
      if (i == 190) drain();
    end
    drain();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && writes_pending == 0) begin
      $display("midi_note_to_psg_register_writes test passed");
    end else begin
      $display("midi_note_to_psg_register_writes test failed");
    end
    $finish;
  end

endmodule
